// ===== rtl/hpi_pkg.sv =====
// hillshade pixel index package: widths, register indexes, shared types
// used by hpi_isqrt, hpi_div and hillshade_pixel_index_unit; no dependencies
package hpi_pkg;

    localparam int MAG_W    = 50;
    localparam int ROOT_W   = 25;
    localparam int NUM_W    = 36;
    localparam int QUO_W    = 10;
    localparam int INDEX_W  = 15;
    localparam int ADDR_W   = 5;

    localparam logic [2:0] REG_SUN_X        = 3'd0;
    localparam logic [2:0] REG_SUN_Y        = 3'd1;
    localparam logic [2:0] REG_SUN_Z        = 3'd2;
    localparam logic [2:0] REG_CONTRAST     = 3'd3;
    localparam logic [2:0] REG_HEIGHT_SHIFT = 3'd4;
    localparam logic [2:0] REG_PIXEL_SIZE   = 3'd5;
    localparam logic [2:0] REG_SHADING_ON   = 3'd6;

    localparam logic [14:0] WATER_INDEX = 15'(255 + 64 * 256);
    localparam logic [6:0]  SHADE_MID   = 7'd64;

    typedef struct packed {
        logic        skip;
        logic [14:0] base;
        logic [7:0]  level;
    } side_t;

endpackage

// ===== rtl/hpi_isqrt.sv =====
// pipelined floor square root, one result bit per stage
// depends on hpi_pkg; carries the word's sideband and numerator alongside
module hpi_isqrt (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [hpi_pkg::MAG_W-1:0]         in_mag,
    input  hpi_pkg::side_t                    in_side,
    input  logic signed [hpi_pkg::NUM_W-1:0]  in_num,
    output logic                              out_valid,
    output logic [hpi_pkg::ROOT_W-1:0]        out_root,
    output hpi_pkg::side_t                    out_side,
    output logic signed [hpi_pkg::NUM_W-1:0]  out_num
);

    localparam int N = hpi_pkg::ROOT_W;
    localparam int RW = 29;

    logic                             valid_reg [0:N-1];
    logic [RW-1:0]                    rem_reg   [0:N-1];
    logic [N-1:0]                     root_reg  [0:N-1];
    logic [hpi_pkg::MAG_W-1:0]        mag_reg   [0:N-1];
    hpi_pkg::side_t                   side_reg  [0:N-1];
    logic signed [hpi_pkg::NUM_W-1:0] num_reg   [0:N-1];

    genvar j;
    generate
        for (j = 0; j < N; j++) begin : g_stage
            logic                             v_prev;
            logic [RW-1:0]                    rem_prev;
            logic [N-1:0]                     root_prev;
            logic [hpi_pkg::MAG_W-1:0]        mag_prev;
            hpi_pkg::side_t                   side_prev;
            logic signed [hpi_pkg::NUM_W-1:0] num_prev;
            logic [RW-1:0]                    rem_sh;
            logic [RW-1:0]                    trial;
            logic [RW-1:0]                    rem_next;
            logic [N-1:0]                     root_next;

            if (j == 0) begin : g_first
                assign v_prev    = in_valid;
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign mag_prev  = in_mag;
                assign side_prev = in_side;
                assign num_prev  = in_num;
            end else begin : g_next
                assign v_prev    = valid_reg[j-1];
                assign rem_prev  = rem_reg[j-1];
                assign root_prev = root_reg[j-1];
                assign mag_prev  = mag_reg[j-1];
                assign side_prev = side_reg[j-1];
                assign num_prev  = num_reg[j-1];
            end

            always_comb begin
                rem_sh = {rem_prev[RW-3:0], mag_prev[hpi_pkg::MAG_W-1-2*j -: 2]};
                trial  = {2'b00, root_prev, 2'b01};
                if (rem_sh >= trial) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_prev[N-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_prev[N-2:0], 1'b0};
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[j] <= 1'b0;
                end else if (en) begin
                    valid_reg[j] <= v_prev;
                end
                if (en) begin
                    rem_reg[j]  <= rem_next;
                    root_reg[j] <= root_next;
                    mag_reg[j]  <= mag_prev;
                    side_reg[j] <= side_prev;
                    num_reg[j]  <= num_prev;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_num   = num_reg[N-1];

endmodule

// ===== rtl/hpi_div.sv =====
// pipelined signed divide by the root, truncating toward zero
// depends on hpi_pkg; quotient magnitude stays below 2**QUO_W
module hpi_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [hpi_pkg::NUM_W-1:0]  in_num,
    input  logic [hpi_pkg::ROOT_W-1:0]        in_root,
    input  hpi_pkg::side_t                    in_side,
    output logic                              out_valid,
    output logic signed [hpi_pkg::QUO_W:0]    out_quo,
    output hpi_pkg::side_t                    out_side
);

    localparam int N  = hpi_pkg::QUO_W;
    localparam int AW = hpi_pkg::NUM_W;

    logic                          a_valid_reg;
    logic [AW-1:0]                 a_mag_reg;
    logic                          a_neg_reg;
    logic [hpi_pkg::ROOT_W-1:0]    a_root_reg;
    hpi_pkg::side_t                a_side_reg;
    logic [AW-1:0]                 a_mag_next;

    logic                          valid_reg [0:N-1];
    logic [AW-1:0]                 rem_reg   [0:N-1];
    logic [N-1:0]                  quo_reg   [0:N-1];
    logic                          neg_reg   [0:N-1];
    logic [hpi_pkg::ROOT_W-1:0]    root_reg  [0:N-1];
    hpi_pkg::side_t                side_reg  [0:N-1];

    assign a_mag_next = in_num[AW-1] ? AW'(-in_num) : AW'(in_num);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
        if (en) begin
            a_mag_reg  <= a_mag_next;
            a_neg_reg  <= in_num[AW-1];
            a_root_reg <= in_root;
            a_side_reg <= in_side;
        end
    end

    genvar j;
    generate
        for (j = 0; j < N; j++) begin : g_stage
            logic                       v_prev;
            logic [AW-1:0]              rem_prev;
            logic [N-1:0]               quo_prev;
            logic                       neg_prev;
            logic [hpi_pkg::ROOT_W-1:0] root_prev;
            hpi_pkg::side_t             side_prev;
            logic [AW-1:0]              shifted;
            logic [AW-1:0]              rem_next;
            logic [N-1:0]               quo_next;

            if (j == 0) begin : g_first
                assign v_prev    = a_valid_reg;
                assign rem_prev  = a_mag_reg;
                assign quo_prev  = '0;
                assign neg_prev  = a_neg_reg;
                assign root_prev = a_root_reg;
                assign side_prev = a_side_reg;
            end else begin : g_next
                assign v_prev    = valid_reg[j-1];
                assign rem_prev  = rem_reg[j-1];
                assign quo_prev  = quo_reg[j-1];
                assign neg_prev  = neg_reg[j-1];
                assign root_prev = root_reg[j-1];
                assign side_prev = side_reg[j-1];
            end

            always_comb begin
                shifted  = AW'(root_prev) << (N - 1 - j);
                rem_next = rem_prev;
                quo_next = quo_prev;
                if (rem_prev >= shifted) begin
                    rem_next = rem_prev - shifted;
                    quo_next[N-1-j] = 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[j] <= 1'b0;
                end else if (en) begin
                    valid_reg[j] <= v_prev;
                end
                if (en) begin
                    rem_reg[j]  <= rem_next;
                    quo_reg[j]  <= quo_next;
                    neg_reg[j]  <= neg_prev;
                    root_reg[j] <= root_prev;
                    side_reg[j] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[N-1];
    assign out_quo   = neg_reg[N-1] ? -$signed({1'b0, quo_reg[N-1]})
                                    : $signed({1'b0, quo_reg[N-1]});
    assign out_side  = side_reg[N-1];

endmodule

// ===== rtl/hillshade_pixel_index_unit.sv =====
// hillshade pixel index: top level with config registers and normal/shade stages
// depends on hpi_pkg, hpi_isqrt, hpi_div
// 44 register stages from the input accept edge to result valid
// throughput one word per cycle while the output register is empty or taken
// the whole pipeline advances together whenever the output register is empty or taken
// synchronous active-low reset clears valid bits and restores register defaults
module hillshade_pixel_index_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hpi_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [15:0]                    s_centre_height,
    input  logic [15:0]                    s_right_height,
    input  logic [15:0]                    s_left_height,
    input  logic [15:0]                    s_below_height,
    input  logic [15:0]                    s_above_height,
    input  logic [7:0]                     s_horiz_distance,
    input  logic [7:0]                     s_vert_distance,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [hpi_pkg::INDEX_W-1:0]    m_color_index
);

    logic signed [8:0] sun_x_reg;
    logic signed [8:0] sun_y_reg;
    logic [7:0]        sun_z_reg;
    logic [7:0]        contrast_reg;
    logic [2:0]        height_shift_reg;
    logic [13:0]       pixel_size_reg;
    logic              shading_on_reg;
    logic [2:0]        reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sun_x_reg        <= '0;
            sun_y_reg        <= '0;
            sun_z_reg        <= 8'd255;
            contrast_reg     <= 8'd150;
            height_shift_reg <= 3'd4;
            pixel_size_reg   <= 14'd1;
            shading_on_reg   <= 1'b1;
        end else if (wr_en) begin
            case (reg_idx)
                hpi_pkg::REG_SUN_X:        sun_x_reg        <= $signed(pwdata[8:0]);
                hpi_pkg::REG_SUN_Y:        sun_y_reg        <= $signed(pwdata[8:0]);
                hpi_pkg::REG_SUN_Z:        sun_z_reg        <= pwdata[7:0];
                hpi_pkg::REG_CONTRAST:     contrast_reg     <= pwdata[7:0];
                hpi_pkg::REG_HEIGHT_SHIFT: height_shift_reg <= pwdata[2:0];
                hpi_pkg::REG_PIXEL_SIZE:   pixel_size_reg   <= pwdata[13:0];
                hpi_pkg::REG_SHADING_ON:   shading_on_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            hpi_pkg::REG_SUN_X:        prdata = {23'd0, sun_x_reg};
            hpi_pkg::REG_SUN_Y:        prdata = {23'd0, sun_y_reg};
            hpi_pkg::REG_SUN_Z:        prdata = {24'd0, sun_z_reg};
            hpi_pkg::REG_CONTRAST:     prdata = {24'd0, contrast_reg};
            hpi_pkg::REG_HEIGHT_SHIFT: prdata = {29'd0, height_shift_reg};
            hpi_pkg::REG_PIXEL_SIZE:   prdata = {18'd0, pixel_size_reg};
            hpi_pkg::REG_SHADING_ON:   prdata = {31'd0, shading_on_reg};
            default:                   prdata = '0;
        endcase
    end

    logic en;
    logic out_valid_reg;
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    // stage 1: differences, level, bypass
    logic                 v1_reg;
    hpi_pkg::side_t       side1_reg;
    logic signed [24:0]   d0_1_reg;
    logic signed [24:0]   d1_1_reg;
    logic [15:0]          hv1_reg;
    logic                 water;
    logic [15:0]          lvl_full;
    logic [7:0]           level;
    logic signed [16:0]   dx;
    logic signed [16:0]   dy;
    logic signed [25:0]   d0_full;
    logic signed [25:0]   d1_full;
    hpi_pkg::side_t       side1_next;

    always_comb begin
        water    = (s_centre_height == 16'd0) || s_centre_height[15];
        lvl_full = s_centre_height >> height_shift_reg;
        level    = (|lvl_full[15:8]) ? 8'hFF : lvl_full[7:0];
        dx       = $signed({1'b0, s_right_height}) - $signed({1'b0, s_left_height});
        dy       = $signed({1'b0, s_below_height}) - $signed({1'b0, s_above_height});
        d0_full  = dx * $signed({1'b0, s_vert_distance});
        d1_full  = dy * $signed({1'b0, s_horiz_distance});
        side1_next.skip  = water || !shading_on_reg || (dx == 17'sd0 && dy == 17'sd0);
        side1_next.base  = water ? hpi_pkg::WATER_INDEX : {hpi_pkg::SHADE_MID, level};
        side1_next.level = level;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
        if (en) begin
            side1_reg <= side1_next;
            d0_1_reg  <= d0_full[24:0];
            d1_1_reg  <= d1_full[24:0];
            hv1_reg   <= 16'(s_horiz_distance * s_vert_distance);
        end
    end

    // stage 2: vertical term
    logic                 v2_reg;
    hpi_pkg::side_t       side2_reg;
    logic signed [24:0]   d0_2_reg;
    logic signed [24:0]   d1_2_reg;
    logic [29:0]          d2_2_reg;
    logic [13:0]          hscale;

    assign hscale = (pixel_size_reg == 14'd0) ? 14'd1 : pixel_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            side2_reg <= side1_reg;
            d0_2_reg  <= d0_1_reg;
            d1_2_reg  <= d1_1_reg;
            d2_2_reg  <= 30'(hv1_reg * hscale);
        end
    end

    // stage 3: halving count
    logic                 v3_reg;
    hpi_pkg::side_t       side3_reg;
    logic signed [24:0]   d0_3_reg;
    logic signed [24:0]   d1_3_reg;
    logic [29:0]          d2_3_reg;
    logic [4:0]           k3_reg;
    logic [4:0]           k_next;

    always_comb begin
        k_next = 5'd0;
        for (int i = 21; i >= 0; i--) begin
            if ((d2_2_reg >> i) <= 30'd512) begin
                k_next = 5'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            side3_reg <= side2_reg;
            d0_3_reg  <= d0_2_reg;
            d1_3_reg  <= d1_2_reg;
            d2_3_reg  <= d2_2_reg;
            k3_reg    <= k_next;
        end
    end

    // stage 4: scaled normal
    logic                 v4_reg;
    hpi_pkg::side_t       side4_reg;
    logic signed [24:0]   d0_4_reg;
    logic signed [24:0]   d1_4_reg;
    logic [9:0]           d2_4_reg;
    logic [23:0]          abs0;
    logic [23:0]          abs1;
    logic [23:0]          sh0;
    logic [23:0]          sh1;
    logic [29:0]          sh2;

    always_comb begin
        abs0 = d0_3_reg[24] ? 24'(-d0_3_reg) : d0_3_reg[23:0];
        abs1 = d1_3_reg[24] ? 24'(-d1_3_reg) : d1_3_reg[23:0];
        sh0  = abs0 >> k3_reg;
        sh1  = abs1 >> k3_reg;
        sh2  = d2_3_reg >> k3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            side4_reg <= side3_reg;
            d0_4_reg  <= d0_3_reg[24] ? -$signed({1'b0, sh0}) : $signed({1'b0, sh0});
            d1_4_reg  <= d1_3_reg[24] ? -$signed({1'b0, sh1}) : $signed({1'b0, sh1});
            d2_4_reg  <= sh2[9:0];
        end
    end

    // stage 5: squares and sun products
    logic                 v5_reg;
    hpi_pkg::side_t       side5_reg;
    logic [47:0]          sq0_reg;
    logic [47:0]          sq1_reg;
    logic [19:0]          sq2_reg;
    logic signed [33:0]   n0_reg;
    logic signed [33:0]   n1_reg;
    logic signed [19:0]   n2_reg;
    logic signed [49:0]   sq0_full;
    logic signed [49:0]   sq1_full;
    logic signed [33:0]   n0_full;
    logic signed [33:0]   n1_full;
    logic signed [19:0]   n2_full;

    always_comb begin
        sq0_full = d0_4_reg * d0_4_reg;
        sq1_full = d1_4_reg * d1_4_reg;
        n0_full  = d0_4_reg * sun_x_reg;
        n1_full  = d1_4_reg * sun_y_reg;
        n2_full  = $signed({1'b0, d2_4_reg}) * $signed({1'b0, sun_z_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
        if (en) begin
            side5_reg <= side4_reg;
            sq0_reg   <= sq0_full[47:0];
            sq1_reg   <= sq1_full[47:0];
            sq2_reg   <= 20'(d2_4_reg * d2_4_reg);
            n0_reg    <= n0_full;
            n1_reg    <= n1_full;
            n2_reg    <= n2_full;
        end
    end

    // stage 6: magnitude and numerator sums
    logic                             v6_reg;
    hpi_pkg::side_t                   side6_reg;
    logic [hpi_pkg::MAG_W-1:0]        mag6_reg;
    logic signed [hpi_pkg::NUM_W-1:0] num6_reg;
    logic [hpi_pkg::MAG_W-1:0]        mag_next;
    hpi_pkg::side_t                   side6_next;

    always_comb begin
        mag_next   = hpi_pkg::MAG_W'(sq0_reg) + hpi_pkg::MAG_W'(sq1_reg)
                   + hpi_pkg::MAG_W'(sq2_reg);
        side6_next = side5_reg;
        if (mag_next == '0) begin
            side6_next.skip = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
        if (en) begin
            side6_reg <= side6_next;
            mag6_reg  <= mag_next;
            num6_reg  <= hpi_pkg::NUM_W'(n0_reg) + hpi_pkg::NUM_W'(n1_reg)
                       + hpi_pkg::NUM_W'(n2_reg);
        end
    end

    logic                             sq_valid;
    logic [hpi_pkg::ROOT_W-1:0]       sq_root;
    hpi_pkg::side_t                   sq_side;
    logic signed [hpi_pkg::NUM_W-1:0] sq_num;

    hpi_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .in_mag    (mag6_reg),
        .in_side   (side6_reg),
        .in_num    (num6_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side),
        .out_num   (sq_num)
    );

    logic                                dv_valid;
    logic signed [hpi_pkg::QUO_W:0]      dv_quo;
    hpi_pkg::side_t                      dv_side;

    hpi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_num    (sq_num),
        .in_root   (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // contrast product
    logic                 v7_reg;
    hpi_pkg::side_t       side7_reg;
    logic signed [20:0]   prod7_reg;
    logic signed [11:0]   tq;

    assign tq = 12'(dv_quo) - $signed({4'd0, sun_z_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= dv_valid;
        end
        if (en) begin
            side7_reg <= dv_side;
            prod7_reg <= tq * $signed({1'b0, contrast_reg});
        end
    end

    // scale, clamp and form the index
    logic [hpi_pkg::INDEX_W-1:0] index_reg;
    logic signed [20:0]          adj;
    logic signed [13:0]          shade;
    logic [6:0]                  shade_code;

    always_comb begin
        adj   = prod7_reg + (prod7_reg[20] ? 21'sd127 : 21'sd0);
        shade = 14'(adj >>> 7);
        if (shade > 14'sd63) begin
            shade_code = 7'd127;
        end else if (shade < -14'sd64) begin
            shade_code = 7'd0;
        end else begin
            shade_code = 7'(shade + 14'sd64);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v7_reg;
        end
        if (en) begin
            index_reg <= side7_reg.skip ? side7_reg.base : {shade_code, side7_reg.level};
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_color_index = index_reg;

endmodule

// ===== test/tb_hillshade_pixel_index_unit.sv =====
// testbench for hillshade_pixel_index_unit: directed and random pixels against a local predictor
// depends on hpi_pkg and the unit's rtl; apb register writes between phases
`timescale 1ns / 1ps

class shade_scoreboard;
    logic [14:0] pending_index[$];
    int errors;
    int checked;

    function new();
        errors = 0;
        checked = 0;
    endfunction

    function void note_pixel(logic [14:0] idx);
        pending_index.push_back(idx);
    endfunction

    function void check_index(logic [14:0] got);
        logic [14:0] want;
        if (pending_index.size() == 0) begin
            $error("color_index: expected none, actual %0d", got);
            errors++;
            return;
        end
        want = pending_index.pop_front();
        checked++;
        if (want !== got) begin
            $error("color_index: expected %0d, actual %0d", want, got);
            errors++;
        end
    endfunction
endclass

module tb_hillshade_pixel_index_unit;

    logic aclk = 0;
    logic aresetn = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [hpi_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 0, s_ready;
    logic [15:0] s_centre_height = 0, s_right_height = 0, s_left_height = 0;
    logic [15:0] s_below_height = 0, s_above_height = 0;
    logic [7:0] s_horiz_distance = 1, s_vert_distance = 1;
    logic m_valid, m_ready = 0;
    logic [hpi_pkg::INDEX_W-1:0] m_color_index;

    longint sun_x, sun_y, sun_z, contrast_gain, pix_size;
    int unsigned hshift;
    bit shade_en;
    bit idle_en;
    int fed;
    int stall_left = 0;

    shade_scoreboard board;

    hillshade_pixel_index_unit dut (.*);

    always #2 aclk = ~aclk;

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [14:0] shade_index(logic [15:0] c, logic [15:0] r,
            logic [15:0] l, logic [15:0] b, logic [15:0] a, logic [7:0] hd, logic [7:0] vd);
        longint unsigned lvl, mag;
        longint dx, dy, d0, d1, d2, hs, q, sh, res;
        if (c == 0 || c > 16'd32767) return hpi_pkg::WATER_INDEX;
        lvl = c >> hshift;
        if (lvl > 255) lvl = 255;
        res = lvl + 64 * 256;
        dx = longint'(r) - longint'(l);
        dy = longint'(b) - longint'(a);
        if (shade_en && !(dx == 0 && dy == 0)) begin
            hs = pix_size < 1 ? 1 : pix_size;
            d0 = dx * longint'(vd);
            d1 = longint'(hd) * dy;
            d2 = longint'(hd) * longint'(vd) * hs;
            while (d2 > 512) begin
                d0 /= 2;
                d1 /= 2;
                d2 /= 2;
            end
            mag = d0 * d0 + d1 * d1 + d2 * d2;
            if (mag > 0) begin
                q = (d2 * sun_z + d0 * sun_x + d1 * sun_y) / longint'(isqrt(mag));
                sh = (q - sun_z) * contrast_gain / 128;
                if (sh > 63) sh = 63;
                if (sh < -64) sh = -64;
                res = lvl + (sh + 64) * 256;
            end
        end
        return res[14:0];
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= hpi_pkg::ADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            hpi_pkg::REG_SUN_X: sun_x = longint'($signed(val[8:0]));
            hpi_pkg::REG_SUN_Y: sun_y = longint'($signed(val[8:0]));
            hpi_pkg::REG_SUN_Z: sun_z = val[7:0];
            hpi_pkg::REG_CONTRAST: contrast_gain = val[7:0];
            hpi_pkg::REG_HEIGHT_SHIFT: hshift = val[2:0];
            hpi_pkg::REG_PIXEL_SIZE: pix_size = val[13:0];
            default: shade_en = val[0];
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        while (board.pending_index.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic send_pixel(logic [15:0] c, logic [15:0] r, logic [15:0] l,
            logic [15:0] b, logic [15:0] a, logic [7:0] hd, logic [7:0] vd);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1;
        s_centre_height <= c;
        s_right_height <= r;
        s_left_height <= l;
        s_below_height <= b;
        s_above_height <= a;
        s_horiz_distance <= hd;
        s_vert_distance <= vd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_pixel(shade_index(c, r, l, b, a, hd, vd));
        fed++;
    endtask

    task automatic random_pixels(int n);
        logic [15:0] c, base;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            c = 16'($urandom_range(1, 32767));
            if (k == 0) c = 16'($urandom);
            base = 16'($urandom_range(0, 32767));
            if (k < 3)
                send_pixel(c, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           8'($urandom), 8'($urandom));
            else
                send_pixel(c, base + 16'($urandom_range(0, 200)),
                           base + 16'($urandom_range(0, 200)),
                           base + 16'($urandom_range(0, 200)),
                           base + 16'($urandom_range(0, 200)),
                           8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)));
        end
        s_valid <= 0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_index(m_color_index);
        if (!idle_en) begin
            stall_left = 0;
            m_ready <= 1;
        end else if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) m_ready <= 1;
        end else if (m_ready && $urandom_range(0, 6) == 0) begin
            m_ready <= 0;
            stall_left = $urandom_range(1, 14);
        end else begin
            m_ready <= 1;
        end
    end

    initial begin
        #8000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        board = new();
        sun_x = 0; sun_y = 0; sun_z = 255; contrast_gain = 150;
        hshift = 4; pix_size = 1; shade_en = 1;
        idle_en = 1;
        fed = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // reset defaults, corner pixels
        send_pixel(0, 5, 1, 5, 1, 1, 1);
        send_pixel(16'hFFFF, 5, 1, 5, 1, 1, 1);
        send_pixel(16'd32768, 5, 1, 5, 1, 1, 1);
        send_pixel(16'd32767, 100, 100, 7, 7, 1, 1);
        send_pixel(16'd1, 0, 16'hFFFF, 16'hFFFF, 0, 255, 255);
        send_pixel(16'd4000, 16'hFFFF, 0, 0, 16'hFFFF, 1, 1);
        send_pixel(16'd4000, 0, 0, 0, 0, 0, 0);
        send_pixel(16'd4000, 9, 3, 2, 8, 0, 0);
        send_pixel(16'd4000, 9, 3, 2, 8, 0, 7);
        send_pixel(16'd4000, 300, 1, 1, 300, 3, 200);
        s_valid <= 0;
        drain();
        write_reg(hpi_pkg::REG_SUN_X, 32'h1FF & -255);
        write_reg(hpi_pkg::REG_SUN_Y, 255);
        write_reg(hpi_pkg::REG_SUN_Z, 0);
        write_reg(hpi_pkg::REG_CONTRAST, 255);
        write_reg(hpi_pkg::REG_HEIGHT_SHIFT, 0);
        write_reg(hpi_pkg::REG_PIXEL_SIZE, 0);
        write_reg(hpi_pkg::REG_SHADING_ON, 0);
        send_pixel(16'd100, 9, 3, 2, 8, 1, 1);
        send_pixel(16'd300, 9, 3, 2, 8, 1, 1);
        s_valid <= 0;
        drain();
        write_reg(hpi_pkg::REG_SHADING_ON, 1);
        write_reg(hpi_pkg::REG_HEIGHT_SHIFT, 7);
        random_pixels(300);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(hpi_pkg::REG_SUN_X, $urandom);
            write_reg(hpi_pkg::REG_SUN_Y, $urandom);
            write_reg(hpi_pkg::REG_SUN_Z, $urandom);
            write_reg(hpi_pkg::REG_CONTRAST, $urandom);
            write_reg(hpi_pkg::REG_HEIGHT_SHIFT, $urandom);
            write_reg(hpi_pkg::REG_PIXEL_SIZE, ph == 0 ? 16383 : $urandom_range(1, 40));
            write_reg(hpi_pkg::REG_SHADING_ON, 32'(ph != 3 || $urandom_range(0, 1)));
            if (ph == 3) idle_en = 0;
            random_pixels(300);
            drain();
        end
        $display("fed %0d pixels over seven register settings, %0d results checked",
                 fed, board.checked);
        if (board.errors == 0 && board.pending_index.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/hpi_pkg.sv
rtl/hpi_isqrt.sv
rtl/hpi_div.sv
rtl/hillshade_pixel_index_unit.sv
test/tb_hillshade_pixel_index_unit.sv
